@@ hdl/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;

  // Field widths
  localparam int OFF_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;

  // Screen store addressing; the sweep counter also holds CELLS itself
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(CELLS + 1);

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  // Color register indexes
  localparam logic [1:0] REG_DEFAULT_COLOR = 2'd0;
  localparam logic [1:0] REG_PROMPT_COLOR  = 2'd1;
  localparam logic [1:0] REG_ERROR_COLOR   = 2'd2;
  localparam logic [1:0] REG_INPUT_COLOR   = 2'd3;

  typedef logic [OFF_W-1:0] off_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [AW-1:0]    addr_t;
  typedef logic [CW-1:0]    cnt_t;

  typedef enum logic [1:0] {
    OP_PRINT      = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  typedef struct packed {
    off_t offset;
    col_t col;
    row_t row;
  } cursor_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic [ATTR_W-1:0] attr;
  } cell_t;

endpackage

@@ hdl/tcw_cursor.sv @@
`timescale 1ns / 1ps

// Next-cursor logic: print advance, newline, tab, positioning, scroll detect.
module tcw_cursor (
  input  tcw_pkg::cursor_t      cur_i,
  input  tcw_pkg::op_e          op_i,
  input  logic [7:0]            char_code_i,
  input  logic [6:0]            column_i,
  input  logic [4:0]            row_i,
  output tcw_pkg::cursor_t      nxt_o,
  output tcw_pkg::off_t         cell_idx_o,
  output logic                  put_char_o,
  output logic                  scroll_o
);

  tcw_pkg::col_t              col_sat;
  tcw_pkg::row_t              row_sat;
  tcw_pkg::off_t              adv;
  logic [tcw_pkg::OFF_W:0]    off_sum;
  logic [tcw_pkg::COL_W:0]    col_sum;
  logic [tcw_pkg::ROW_W:0]    row_nxt;
  tcw_pkg::col_t              col_nxt;
  tcw_pkg::cursor_t           prt;

  // saturate requested position
  assign col_sat = (int'(column_i) >= tcw_pkg::COLUMNS) ?
                   tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1) : column_i;
  assign row_sat = (int'(row_i) >= tcw_pkg::ROWS) ?
                   tcw_pkg::row_t'(tcw_pkg::ROWS - 1) : row_i;
  assign cell_idx_o = tcw_pkg::off_t'(row_sat * tcw_pkg::COLUMNS)
                    + tcw_pkg::off_t'(col_sat);

  assign put_char_o = (char_code_i != tcw_pkg::CH_NEWLINE)
                   && (char_code_i != tcw_pkg::CH_TAB);

  always_comb begin
    if (char_code_i == tcw_pkg::CH_NEWLINE) begin
      adv = tcw_pkg::off_t'(tcw_pkg::COLUMNS) - tcw_pkg::off_t'(cur_i.col);
    end else if (char_code_i == tcw_pkg::CH_TAB) begin
      adv = tcw_pkg::off_t'(tcw_pkg::TAB_STOP)
          - tcw_pkg::off_t'(cur_i.offset % tcw_pkg::TAB_STOP);
    end else begin
      adv = tcw_pkg::off_t'(1);
    end
  end

  always_comb begin
    off_sum = {1'b0, cur_i.offset} + {1'b0, adv};
    col_sum = {1'b0, cur_i.col} + (tcw_pkg::COL_W + 1)'(adv);
    if (int'(col_sum) >= tcw_pkg::COLUMNS) begin
      col_nxt = tcw_pkg::col_t'(col_sum - (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS));
      row_nxt = {1'b0, cur_i.row} + (tcw_pkg::ROW_W + 1)'(1);
    end else begin
      col_nxt = col_sum[tcw_pkg::COL_W-1:0];
      row_nxt = {1'b0, cur_i.row};
    end
    // past the last cell: bottom row start after the scroll
    if (int'(row_nxt) >= tcw_pkg::ROWS) begin
      prt.offset = tcw_pkg::off_t'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
      prt.col    = '0;
      prt.row    = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
    end else begin
      prt.offset = off_sum[tcw_pkg::OFF_W-1:0];
      prt.col    = col_nxt;
      prt.row    = row_nxt[tcw_pkg::ROW_W-1:0];
    end
  end

  always_comb begin
    scroll_o = 1'b0;
    unique case (op_i)
      tcw_pkg::OP_PRINT: begin
        nxt_o    = prt;
        scroll_o = int'(row_nxt) >= tcw_pkg::ROWS;
      end
      tcw_pkg::OP_SET_CURSOR: begin
        nxt_o.offset = cell_idx_o;
        nxt_o.col    = col_sat;
        nxt_o.row    = row_sat;
      end
      tcw_pkg::OP_CLEAR: nxt_o = '0;
      tcw_pkg::OP_READ:  nxt_o = cur_i;
      default:           nxt_o = cur_i;
    endcase
  end

endmodule

@@ hdl/text_console_writer_unit.sv @@
`timescale 1ns / 1ps

// Text console writer. One item per start pulse (taken when busy_o is low);
// each item gives exactly one result, shown for a single cycle with done_o
// high, which the receiver must take then. A print with no scroll, set
// cursor and read cell go straight from accept to result; the read comes
// from the screen store's registered read port. Clear walks the whole store
// one cell a cycle. A print, newline or tab that runs past the last cell
// scrolls: one read-write pass moves 1920 cells up a row, each write-back
// overlapped with the next read, then the 80 cells of the bottom row are
// blanked. After reset the store is zeroed by a pass over all 2000 cells
// with busy_o high. Color registers are written through the cfg port (always
// ready); write them only while the unit is idle.
module text_console_writer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  char_code_i,
  input  logic [1:0]  message_kind_i,
  input  logic [6:0]  column_i,
  input  logic [4:0]  row_i,
  // result
  output logic        done_o,
  output logic [10:0] cursor_offset_o,
  output logic [6:0]  cursor_column_o,
  output logic [4:0]  cursor_row_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attribute_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RESP   = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_FILL   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  tcw_pkg::cursor_t  cursor_q, cursor_d;
  tcw_pkg::cnt_t     cnt_q, cnt_d;
  tcw_pkg::cell_t    fill_data_q, fill_data_d;
  logic              fill_resp_q, fill_resp_d;
  logic              rd_op_q, rd_op_d;
  logic [7:0]        color_q [4];

  tcw_pkg::cell_t    screen_mem [tcw_pkg::CELLS];
  tcw_pkg::cell_t    rdata_q;
  logic              mem_we, mem_re;
  tcw_pkg::addr_t    mem_waddr, mem_raddr;
  tcw_pkg::cell_t    mem_wdata;

  logic              accept;
  tcw_pkg::op_e      op;
  tcw_pkg::cursor_t  cur_nxt;
  tcw_pkg::off_t     cell_idx;
  logic              put_char, scroll;
  tcw_pkg::cell_t    blank;

  assign op          = tcw_pkg::op_e'(operation_i);
  assign busy_o      = state_q != ST_IDLE;
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign blank       = '{chr: tcw_pkg::CH_SPACE, attr: color_q[tcw_pkg::REG_DEFAULT_COLOR]};

  tcw_cursor u_cursor (
    .cur_i       (cursor_q),
    .op_i        (op),
    .char_code_i (char_code_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .nxt_o       (cur_nxt),
    .cell_idx_o  (cell_idx),
    .put_char_o  (put_char),
    .scroll_o    (scroll)
  );

  // color registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) color_q[i] <= 8'd7;
    end else if (cfg_valid_i) begin
      color_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    cnt_d       = cnt_q;
    fill_data_d = fill_data_q;
    fill_resp_d = fill_resp_q;
    rd_op_d     = rd_op_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cursor_d = cur_nxt;
          rd_op_d  = op == tcw_pkg::OP_READ;
          state_d  = ST_RESP;
          unique case (op)
            tcw_pkg::OP_PRINT: begin
              mem_we    = put_char;
              mem_waddr = tcw_pkg::addr_t'(cursor_q.offset);
              mem_wdata = '{chr: char_code_i, attr: color_q[message_kind_i]};
              if (scroll) begin
                cnt_d   = tcw_pkg::cnt_t'(tcw_pkg::COLUMNS);
                state_d = ST_SCROLL;
              end
            end
            tcw_pkg::OP_SET_CURSOR: ;
            tcw_pkg::OP_CLEAR: begin
              cnt_d       = '0;
              fill_data_d = blank;
              fill_resp_d = 1'b1;
              state_d     = ST_FILL;
            end
            tcw_pkg::OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = tcw_pkg::addr_t'(cell_idx);
            end
            default: ;
          endcase
        end
      end
      ST_RESP: state_d = ST_IDLE;
      ST_SCROLL: begin
        // read cell n, write it back one row up on the next cycle
        mem_re    = int'(cnt_q) < tcw_pkg::CELLS;
        mem_raddr = cnt_q[tcw_pkg::AW-1:0];
        mem_we    = int'(cnt_q) > tcw_pkg::COLUMNS;
        mem_waddr = tcw_pkg::addr_t'(cnt_q - tcw_pkg::cnt_t'(tcw_pkg::COLUMNS + 1));
        mem_wdata = rdata_q;
        cnt_d     = cnt_q + tcw_pkg::cnt_t'(1);
        if (int'(cnt_q) == tcw_pkg::CELLS) begin
          cnt_d       = tcw_pkg::cnt_t'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
          fill_data_d = blank;
          fill_resp_d = 1'b1;
          state_d     = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[tcw_pkg::AW-1:0];
        mem_wdata = fill_data_q;
        cnt_d     = cnt_q + tcw_pkg::cnt_t'(1);
        if (int'(cnt_q) == tcw_pkg::CELLS - 1) begin
          state_d = fill_resp_q ? ST_RESP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // reset starts with a zeroing pass over the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cursor_q    <= '0;
      cnt_q       <= '0;
      fill_data_q <= '0;
      fill_resp_q <= 1'b0;
      rd_op_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      cnt_q       <= cnt_d;
      fill_data_q <= fill_data_d;
      fill_resp_q <= fill_resp_d;
      rd_op_q     <= rd_op_d;
    end
  end

  // screen store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= screen_mem[mem_raddr];
    end
  end

  assign done_o           = state_q == ST_RESP;
  assign cursor_offset_o  = cursor_q.offset;
  assign cursor_column_o  = cursor_q.col;
  assign cursor_row_o     = cursor_q.row;
  assign cell_char_o      = rd_op_q ? rdata_q.chr  : 8'd0;
  assign cell_attribute_o = rd_op_q ? rdata_q.attr : 8'd0;

  // checks
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("not busy after accepting an item");

  a_cursor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(cursor_column_o) < tcw_pkg::COLUMNS)
            && (int'(cursor_row_o) < tcw_pkg::ROWS))
    else $error("cursor out of screen");

  a_cursor_coherent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> cursor_offset_o == tcw_pkg::off_t'(int'(cursor_row_o) * tcw_pkg::COLUMNS
                                  + int'(cursor_column_o)))
    else $error("cursor offset disagrees with row and column");

endmodule

@@ bench/tb_text_console_writer_unit.sv @@
`timescale 1ns / 1ps

// Bench for the text console writer: directed corner items, then random
// phases under different color settings. A shadow console (screen store,
// print offset, color registers) predicts every result at acceptance.
module tb_text_console_writer_unit;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int PHASES          = 5;
  localparam int PHASE_ITEMS     = 366;
  localparam int SETTLE_CYCLES   = 4;     // idle cycles before a color write
  localparam int DRAIN_CYCLES    = 50;
  localparam int WATCHDOG_CYCLES = 20000; // > reset sweep + scroll/clear walk

  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_PROMPT  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_INPUT   = 2'd3;

  // What the driver does with one queue entry
  typedef enum logic [1:0] {
    ACT_ITEM,   // console command
    ACT_CFG,    // color register write, once the unit is idle
    ACT_SYNC    // hold off until every result is back
  } cmd_act_e;

  typedef enum logic [2:0] {
    DRV_NEXT, DRV_GAP, DRV_START, DRV_SYNC, DRV_CFG, DRV_DONE
  } drv_state_e;

  typedef struct {
    cmd_act_e      act;
    tcw_pkg::op_e  op;
    logic [7:0]    chr;
    logic [1:0]    kind;
    logic [6:0]    col;
    logic [4:0]    row;
    logic [1:0]    reg_idx;
    logic [7:0]    reg_val;
    int            gap;
  } console_cmd_t;

  typedef struct packed {
    tcw_pkg::cursor_t cur;
    tcw_pkg::cell_t   tile;
  } console_result_t;

  // DUT ports; every input is known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  logic [1:0]  operation_i     = '0;
  logic [7:0]  char_code_i     = '0;
  logic [1:0]  message_kind_i  = '0;
  logic [6:0]  column_i        = '0;
  logic [4:0]  row_i           = '0;
  logic        cfg_valid_i     = 1'b0;
  logic [1:0]  cfg_index_i     = '0;
  logic [7:0]  cfg_data_i      = '0;
  logic        busy_o;
  logic        done_o;
  logic [10:0] cursor_offset_o;
  logic [6:0]  cursor_column_o;
  logic [4:0]  cursor_row_o;
  logic [7:0]  cell_char_o;
  logic [7:0]  cell_attribute_o;
  logic        cfg_ready_o;

  // Shadow console state
  logic [7:0] screen_chr  [tcw_pkg::CELLS];
  logic [7:0] screen_attr [tcw_pkg::CELLS];
  logic [7:0] color_reg   [4];
  int         print_pos;

  console_cmd_t    console_cmds[$];     // items still to send
  console_result_t console_results[$];  // results owed by the unit

  drv_state_e   drv_state = DRV_NEXT;
  console_cmd_t cur_cmd;
  int           gap_left;
  int           settle;
  int           idle_cycles = 0;
  int           mismatches = 0;

  // Stimulus shaping
  int          burst_left = 0;
  logic [6:0]  last_col   = '0;  // last cursor set, saturated; reads aim near it
  logic [4:0]  last_row   = '0;

  text_console_writer_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .char_code_i      (char_code_i),
    .message_kind_i   (message_kind_i),
    .column_i         (column_i),
    .row_i            (row_i),
    .done_o           (done_o),
    .cursor_offset_o  (cursor_offset_o),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o),
    .cell_char_o      (cell_char_o),
    .cell_attribute_o (cell_attribute_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow console
  // ---------------------------------------------------------------------------

  // Out-of-range column or row saturates to the last one
  function automatic int cell_addr(input logic [6:0] col, input logic [4:0] row);
    int c;
    int r;
    c = col;
    r = row;
    if (c >= tcw_pkg::COLUMNS) c = tcw_pkg::COLUMNS - 1;
    if (r >= tcw_pkg::ROWS) r = tcw_pkg::ROWS - 1;
    return r * tcw_pkg::COLUMNS + c;
  endfunction

  task automatic blank_cells(input int first, input int count);
    for (int i = first; i < first + count; i++) begin
      screen_chr[i]  = tcw_pkg::CH_SPACE;
      screen_attr[i] = color_reg[tcw_pkg::REG_DEFAULT_COLOR];
    end
  endtask

  // Applies one accepted item and queues the result it owes
  task automatic console_step(input console_cmd_t c);
    console_result_t r;
    int pos;
    int idx;
    r   = '0;
    pos = print_pos;
    case (c.op)
      tcw_pkg::OP_PRINT: begin
        if (c.chr == tcw_pkg::CH_NEWLINE) begin
          pos += tcw_pkg::COLUMNS - pos % tcw_pkg::COLUMNS;
        end else if (c.chr == tcw_pkg::CH_TAB) begin
          pos += tcw_pkg::TAB_STOP - pos % tcw_pkg::TAB_STOP;
        end else begin
          // any other byte, control codes too, lands in the store
          screen_chr[pos]  = c.chr;
          screen_attr[pos] = color_reg[c.kind];
          pos++;
        end
        // ran past the last cell: move everything up a row
        if (pos >= tcw_pkg::CELLS) begin
          for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++) begin
            screen_chr[i]  = screen_chr[i + tcw_pkg::COLUMNS];
            screen_attr[i] = screen_attr[i + tcw_pkg::COLUMNS];
          end
          blank_cells(tcw_pkg::CELLS - tcw_pkg::COLUMNS, tcw_pkg::COLUMNS);
          pos = tcw_pkg::CELLS - tcw_pkg::COLUMNS;
        end
      end
      tcw_pkg::OP_SET_CURSOR: pos = cell_addr(c.col, c.row);
      tcw_pkg::OP_CLEAR: begin
        blank_cells(0, tcw_pkg::CELLS);
        pos = 0;
      end
      default: begin
        idx = cell_addr(c.col, c.row);
        r.tile.chr  = screen_chr[idx];
        r.tile.attr = screen_attr[idx];
      end
    endcase
    print_pos    = pos;
    r.cur.offset = tcw_pkg::off_t'(pos);
    r.cur.col    = tcw_pkg::col_t'(pos % tcw_pkg::COLUMNS);
    r.cur.row    = tcw_pkg::row_t'(pos / tcw_pkg::COLUMNS);
    console_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // Gap per item is 0..11, with occasional back-to-back bursts
  task automatic add_item(input tcw_pkg::op_e op, input logic [7:0] chr,
                          input logic [1:0] kind, input logic [6:0] col,
                          input logic [4:0] row);
    console_cmd_t c;
    c = '{act: ACT_ITEM, op: op, chr: chr, kind: kind, col: col, row: row,
          reg_idx: '0, reg_val: '0, gap: 0};
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
    end else begin
      c.gap = $urandom_range(0, 11);
    end
    console_cmds.push_back(c);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [7:0] val);
    console_cmds.push_back('{act: ACT_CFG, op: tcw_pkg::OP_PRINT, chr: '0, kind: '0,
                             col: '0, row: '0, reg_idx: idx, reg_val: val, gap: 0});
  endtask

  task automatic add_sync();
    console_cmds.push_back('{act: ACT_SYNC, op: tcw_pkg::OP_PRINT, chr: '0, kind: '0,
                             col: '0, row: '0, reg_idx: '0, reg_val: '0, gap: 0});
  endtask

  // Random fields that the operation ignores still toggle
  task automatic add_rand(input tcw_pkg::op_e op, input logic [7:0] chr,
                          input logic [6:0] col, input logic [4:0] row);
    add_item(op, chr, 2'($urandom_range(0, 3)), col, row);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one entry at a time from console_cmds
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      // item taken at this edge
      if (drv_state == DRV_START && !busy_o) begin
        console_step(cur_cmd);
        drv_state = DRV_NEXT;
      end
      // color write taken at this edge
      if (drv_state == DRV_CFG && cfg_ready_o) begin
        color_reg[cur_cmd.reg_idx] = cur_cmd.reg_val;
        drv_state = DRV_NEXT;
      end
      if (drv_state == DRV_GAP) begin
        if (gap_left <= 1) begin
          start_i   <= 1'b1;
          drv_state = DRV_START;
        end else begin
          gap_left--;
        end
      end
      // wait for all results plus a few quiet cycles
      if (drv_state == DRV_SYNC) begin
        if (console_results.size() == 0 && !busy_o) begin
          if (settle >= SETTLE_CYCLES) begin
            if (cur_cmd.act == ACT_CFG) begin
              cfg_valid_i <= 1'b1;
              drv_state   = DRV_CFG;
            end else begin
              drv_state = DRV_NEXT;
            end
          end else begin
            settle++;
          end
        end else begin
          settle = 0;
        end
      end
      // fetch; start stays high across back-to-back items
      if (drv_state == DRV_NEXT) begin
        cfg_valid_i <= 1'b0;
        if (console_cmds.size() == 0) begin
          start_i   <= 1'b0;
          drv_state = DRV_DONE;
        end else begin
          cur_cmd = console_cmds.pop_front();
          settle  = 0;
          case (cur_cmd.act)
            ACT_ITEM: begin
              operation_i    <= cur_cmd.op;
              char_code_i    <= cur_cmd.chr;
              message_kind_i <= cur_cmd.kind;
              column_i       <= cur_cmd.col;
              row_i          <= cur_cmd.row;
              if (cur_cmd.gap == 0) begin
                start_i   <= 1'b1;
                drv_state = DRV_START;
              end else begin
                start_i   <= 1'b0;
                gap_left  = cur_cmd.gap;
                drv_state = DRV_GAP;
              end
            end
            ACT_CFG: begin
              start_i     <= 1'b0;
              cfg_index_i <= cur_cmd.reg_idx;
              cfg_data_i  <= cur_cmd.reg_val;
              drv_state   = DRV_SYNC;
            end
            default: begin
              start_i   <= 1'b0;
              drv_state = DRV_SYNC;
            end
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: results come strobed, in order, one per item
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    console_result_t want;
    if (rst_ni && done_o) begin
      if (console_results.size() == 0) begin
        $error("result with no item outstanding (offset %0d)", cursor_offset_o);
        mismatches++;
      end else begin
        want = console_results.pop_front();
        check_field("cursor_offset",  16'(want.cur.offset), 16'(cursor_offset_o));
        check_field("cursor_column",  16'(want.cur.col),    16'(cursor_column_o));
        check_field("cursor_row",     16'(want.cur.row),    16'(cursor_row_o));
        check_field("cell_char",      16'(want.tile.chr),   16'(cell_char_o));
        check_field("cell_attribute", 16'(want.tile.attr),  16'(cell_attribute_o));
      end
    end
  end

  // Watchdog: cycles with no handshake of any kind
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int          pick;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [7:0]  chr;
    logic [7:0]  val;

    // unit comes out of reset with a zeroed store and all colors at 7
    for (int i = 0; i < tcw_pkg::CELLS; i++) begin
      screen_chr[i]  = '0;
      screen_attr[i] = '0;
    end
    for (int i = 0; i < 4; i++) color_reg[i] = 8'd7;
    print_pos = 0;

    // Directed: distinct color per kind so a wrong pick shows
    add_cfg(tcw_pkg::REG_DEFAULT_COLOR, 8'h17);
    add_cfg(tcw_pkg::REG_PROMPT_COLOR,  8'h2E);
    add_cfg(tcw_pkg::REG_ERROR_COLOR,   8'h4F);
    add_cfg(tcw_pkg::REG_INPUT_COLOR,   8'hF0);
    add_item(tcw_pkg::OP_READ,  8'h00, KIND_DEFAULT, 7'd0,   5'd0);   // zeroed store
    add_item(tcw_pkg::OP_PRINT, 8'h48, KIND_DEFAULT, 7'd0,   5'd0);
    add_item(tcw_pkg::OP_PRINT, 8'h00, KIND_PROMPT,  7'd127, 5'd31);
    add_item(tcw_pkg::OP_PRINT, 8'hFF, KIND_ERROR,   7'd0,   5'd0);
    add_item(tcw_pkg::OP_PRINT, 8'h0D, KIND_INPUT,   7'd0,   5'd0);   // control byte kept
    add_item(tcw_pkg::OP_PRINT, tcw_pkg::CH_NEWLINE, KIND_DEFAULT, 7'd0, 5'd0);
    add_item(tcw_pkg::OP_PRINT, tcw_pkg::CH_TAB, KIND_ERROR, 7'd0, 5'd0);
    add_item(tcw_pkg::OP_READ,  8'h00, KIND_DEFAULT, 7'd2,   5'd0);
    add_item(tcw_pkg::OP_SET_CURSOR, 8'h00, KIND_DEFAULT, 7'd127, 5'd31);  // both saturate
    add_item(tcw_pkg::OP_PRINT, 8'h5A, KIND_INPUT,   7'd0,   5'd0);   // last cell, scroll
    add_item(tcw_pkg::OP_READ,  8'h00, KIND_DEFAULT, 7'd79,  5'd23);
    add_item(tcw_pkg::OP_READ,  8'h00, KIND_DEFAULT, 7'd0,   5'd24);  // blanked row
    add_item(tcw_pkg::OP_SET_CURSOR, 8'h00, KIND_DEFAULT, 7'd79, 5'd24);
    add_item(tcw_pkg::OP_PRINT, tcw_pkg::CH_TAB, KIND_DEFAULT, 7'd0, 5'd0);     // tab scrolls
    add_item(tcw_pkg::OP_SET_CURSOR, 8'h00, KIND_DEFAULT, 7'd5, 5'd24);
    add_item(tcw_pkg::OP_PRINT, tcw_pkg::CH_NEWLINE, KIND_DEFAULT, 7'd0, 5'd0); // newline scrolls
    add_item(tcw_pkg::OP_READ,  8'h00, KIND_DEFAULT, 7'd100, 5'd22);  // column saturates
    add_item(tcw_pkg::OP_READ,  8'h00, KIND_DEFAULT, 7'd0,   5'd31);  // row saturates
    add_item(tcw_pkg::OP_SET_CURSOR, 8'h00, KIND_DEFAULT, 7'd0, 5'd0);
    add_item(tcw_pkg::OP_CLEAR, 8'h00, KIND_DEFAULT, 7'd0,   5'd0);
    add_item(tcw_pkg::OP_READ,  8'h00, KIND_DEFAULT, 7'd127, 5'd31);
    add_item(tcw_pkg::OP_PRINT, 8'h41, KIND_PROMPT,  7'd0,   5'd0);

    // Random phases, each behind its own color setting
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < 4; i++) begin
        case (p)
          1:       val = 8'h00;
          2:       val = 8'hFF;
          4:       val = i[0] ? 8'hFF : 8'h00;
          default: val = 8'($urandom_range(0, 255));
        endcase
        add_cfg(2'(i), val);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 149) == 0) add_sync();
        pick = $urandom_range(0, 99);
        col  = 7'($urandom_range(0, 127));
        row  = 5'($urandom_range(0, 31));
        chr  = 8'($urandom_range(0, 255));
        if (pick == 0) begin
          add_rand(tcw_pkg::OP_CLEAR, chr, col, row);
        end else if (pick <= 12) begin
          // half the moves go near the end so prints run into a scroll
          if ($urandom_range(0, 1) == 1) begin
            col = 7'($urandom_range(60, 127));
            row = 5'($urandom_range(24, 31));
          end
          last_col = (col >= tcw_pkg::COLUMNS) ? 7'(tcw_pkg::COLUMNS - 1) : col;
          last_row = (row >= tcw_pkg::ROWS) ? 5'(tcw_pkg::ROWS - 1) : row;
          add_rand(tcw_pkg::OP_SET_CURSOR, chr, col, row);
        end else if (pick <= 27) begin
          // half the reads go at or just after the last cursor set, where prints land
          if ($urandom_range(0, 1) == 1) begin
            col = 7'(last_col + $urandom_range(0, 8));
            row = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(20, 24)) : last_row;
          end
          add_rand(tcw_pkg::OP_READ, chr, col, row);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 8) chr = tcw_pkg::CH_NEWLINE;
          else if (pick < 15) chr = tcw_pkg::CH_TAB;
          add_rand(tcw_pkg::OP_PRINT, chr, col, row);
        end
      end
    end

    // Reset once; the unit then sweeps its store with busy_o high
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(drv_state == DRV_DONE && console_results.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (console_results.size() != 0) begin
      $error("%0d results never arrived", console_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
